// ===== rtl/vrmc_pkg.sv =====
package vrmc_pkg;

  // Width of the per-ray step counter.
  localparam int unsigned STEP_COUNT_BITS = 12;

  typedef logic [STEP_COUNT_BITS-1:0] cnt_t;

  // Largest value the step counter can hold.
  localparam cnt_t CNT_MAX = '1;

  // Transmittance of 1.0 in Q1.23.
  localparam logic [23:0] T_ONE = 24'd8388608;

  // 1.0 in Q1.30 and ln 2 in Q0.30 for the exponential unit.
  localparam logic [30:0] Q30_ONE = 31'd1073741824;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // Exponent arguments at or above 24 * ln 2 give a factor of zero.
  localparam logic [34:0] X_ZERO_DT = 35'd17862266832;

  // Number of terms of the exponential series.
  localparam logic [3:0] EXP_TERMS = 4'd11;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_STEP_SIZE  = 2'd0,
    CFG_MAX_STEPS  = 2'd1,
    CFG_CUTOFF     = 2'd2
  } cfg_idx_e;

  // Reasons a ray ends.
  typedef enum logic [1:0] {
    CAUSE_STEP_LIMIT = 2'd0,
    CAUSE_CUTOFF     = 2'd1,
    CAUSE_HOLDOUT    = 2'd2
  } cause_e;

  // One march sample.
  typedef struct packed {
    logic        first_sample;
    logic        holdout_hit;
    logic [15:0] extinction;
    logic [15:0] scatter_density;
    logic [15:0] emit_density;
    logic [15:0] emit_red;
    logic [15:0] emit_green;
    logic [15:0] emit_blue;
    logic [15:0] lit_red;
    logic [15:0] lit_green;
    logic [15:0] lit_blue;
  } in_t;

  // One finished pixel.
  typedef struct packed {
    logic [15:0] pixel_red;
    logic [15:0] pixel_green;
    logic [15:0] pixel_blue;
    logic [15:0] pixel_alpha;
    logic [1:0]  end_cause;
  } out_t;

  // Configuration registers.
  typedef struct packed {
    logic [15:0] step_size;
    logic [11:0] max_steps;
    logic [23:0] cutoff;
  } cfg_t;

  // A classified sample as it waits between the front and the back.
  typedef struct packed {
    in_t         item;
    logic [16:0] density_sum;
  } work_t;

  // Reciprocal ceil(2^34 / m) for the series divisors two to eleven.
  function automatic logic [33:0] recip(input logic [3:0] m);
    logic [33:0] r;
    case (m)
      4'd2:    r = 34'd8589934592;
      4'd3:    r = 34'd5726623062;
      4'd4:    r = 34'd4294967296;
      4'd5:    r = 34'd3435973837;
      4'd6:    r = 34'd2863311531;
      4'd7:    r = 34'd2454267027;
      4'd8:    r = 34'd2147483648;
      4'd9:    r = 34'd1908874354;
      4'd10:   r = 34'd1717986919;
      4'd11:   r = 34'd1561806290;
      default: r = 34'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/vrmc_front.sv =====
module vrmc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  vrmc_pkg::in_t   in_i,
  output logic            head_valid_o,
  output vrmc_pkg::work_t head_o,
  input  logic            deq_i
);

  vrmc_pkg::work_t ent_q [2];
  logic            wr_q, wr_d;
  logic            rd_q, rd_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            enq;
  vrmc_pkg::work_t new_w;

  // Classify the incoming sample: its total density decides the composite path.
  always_comb begin
    new_w.item        = in_i;
    new_w.density_sum = {1'b0, in_i.scatter_density} + {1'b0, in_i.emit_density};
  end

  assign full         = (cnt_q == 2'd2);
  assign enq          = push && !full;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = ent_q[rd_q];

  // Pointer and fill count of the two-entry queue.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (enq) begin
      wr_d = ~wr_q;
    end
    if (deq_i) begin
      rd_d = ~rd_q;
    end
    if (enq && !deq_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!enq && deq_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (enq) begin
      ent_q[wr_q] <= new_w;
    end
  end

endmodule

// ===== rtl/vrmc_back.sv =====
module vrmc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vrmc_pkg::cfg_t  cfg_i,
  input  logic            head_valid_i,
  input  vrmc_pkg::work_t head_i,
  output logic            deq_o,
  output logic            out_valid_o,
  output vrmc_pkg::out_t  out_o,
  input  logic            pop_i
);

  typedef enum logic [20:0] {
    ST_IDLE  = 21'd1,
    ST_CHECK = 21'd2,
    ST_MULA  = 21'd4,
    ST_MULX  = 21'd8,
    ST_XLOAD = 21'd16,
    ST_RED   = 21'd32,
    ST_EXP0  = 21'd64,
    ST_EXP1  = 21'd128,
    ST_EXP2  = 21'd256,
    ST_EXP3  = 21'd512,
    ST_DT    = 21'd1024,
    ST_WMUL  = 21'd2048,
    ST_WLOAD = 21'd4096,
    ST_NUM0  = 21'd8192,
    ST_NUM1  = 21'd16384,
    ST_NUM2  = 21'd32768,
    ST_DIV   = 21'd65536,
    ST_ACCM  = 21'd131072,
    ST_ACC   = 21'd262144,
    ST_TMUL  = 21'd524288,
    ST_TFIN  = 21'd1048576
  } state_e;

  state_e           st_q, st_d;

  // Ray state.
  logic [23:0]      t_ray_q;
  logic [15:0]      sum_q [3];
  vrmc_pkg::cnt_t   cnt_q;
  logic             active_q;

  // Result buffer.
  logic             out_valid_q;
  vrmc_pkg::out_t   out_q;

  // Datapath registers.
  vrmc_pkg::work_t  item_q;
  logic [63:0]      mul_q;
  logic [34:0]      r_q;
  logic [4:0]       n_q;
  logic [2:0]       bit_q;
  logic [3:0]       m_q;
  logic [29:0]      v_q;
  logic [46:0]      pl_q;
  logic [30:0]      t_q;
  logic [23:0]      dt_q;
  logic [23:0]      w_q;
  logic [1:0]       ch_q;
  logic [31:0]      num_q;
  logic [32:0]      rem_q;
  logic [15:0]      quo_q;
  logic [3:0]       dbit_q;

  // Shared multiplier operands.
  logic [31:0]      mul_a, mul_b;

  logic             fs;
  logic             eff_active;
  logic [23:0]      eff_t;
  vrmc_pkg::cnt_t   eff_cnt;
  vrmc_pkg::cnt_t   lim;
  vrmc_pkg::cnt_t   cnt_inc;
  logic [38:0]      x_val;
  logic             x_big;
  logic [34:0]      red_sh;
  logic [33:0]      rcp;
  logic [64:0]      exp_sum;
  logic [29:0]      exp_quo;
  logic [5:0]       dt_shamt;
  logic [23:0]      dt_calc;
  logic [15:0]      col_e, col_s;
  logic [32:0]      div_sh;
  logic [16:0]      acc_add;
  logic [17:0]      acc_sum;
  logic [15:0]      acc_sat;
  logic [23:0]      t_new;

  logic             fin_en;
  vrmc_pkg::cause_e fin_cause;
  logic [23:0]      fin_t;
  logic             fin_clr;
  logic [23:0]      fin_diff;
  logic [15:0]      fin_alpha;

  // Values the checks see once a first sample has restarted the ray.
  assign fs         = item_q.item.first_sample;
  assign eff_active = fs || active_q;
  assign eff_t      = fs ? vrmc_pkg::T_ONE : t_ray_q;
  assign eff_cnt    = fs ? '0 : cnt_q;
  assign cnt_inc    = cnt_q + vrmc_pkg::cnt_t'(1);

  // Step limit, clipped to what the counter can hold.
  assign lim = (17'(cfg_i.max_steps) > 17'(vrmc_pkg::CNT_MAX)) ?
               vrmc_pkg::CNT_MAX : vrmc_pkg::cnt_t'(cfg_i.max_steps);

  // Exponent argument and its range reduction by ln 2.
  assign x_val  = mul_q[48:10];
  assign x_big  = (x_val >= 39'(vrmc_pkg::X_ZERO_DT));
  assign red_sh = 35'(vrmc_pkg::LN2_Q30) << bit_q;

  // Series term divide by m through a two-part reciprocal product.
  assign rcp     = vrmc_pkg::recip(m_q);
  assign exp_sum = 65'({mul_q[46:0], 17'd0}) + 65'(pl_q);
  assign exp_quo = exp_sum[63:34];

  // Scale the series result back by 2^n into Q1.23.
  assign dt_shamt = {1'b0, n_q} + 6'd7;
  assign dt_calc  = 24'(t_q >> dt_shamt);

  // Colour pair of the channel in work.
  always_comb begin
    case (ch_q)
      2'd0: begin
        col_e = item_q.item.emit_red;
        col_s = item_q.item.lit_red;
      end
      2'd1: begin
        col_e = item_q.item.emit_green;
        col_s = item_q.item.lit_green;
      end
      2'd2: begin
        col_e = item_q.item.emit_blue;
        col_s = item_q.item.lit_blue;
      end
      default: begin
        col_e = 16'd0;
        col_s = 16'd0;
      end
    endcase
  end

  // Weighted mean divide, one quotient bit a cycle.
  assign div_sh = 33'(item_q.density_sum) << dbit_q;

  // Saturating radiance accumulate.
  assign acc_add = mul_q[39:23];
  assign acc_sum = 18'(sum_q[ch_q]) + 18'(acc_add);
  assign acc_sat = (acc_sum > 18'd65535) ? 16'hFFFF : acc_sum[15:0];

  assign t_new = mul_q[46:23];

  // Sequencer: state, multiplier operands and ray end decisions.
  always_comb begin
    st_d      = st_q;
    deq_o     = 1'b0;
    mul_a     = 32'd0;
    mul_b     = 32'd0;
    fin_en    = 1'b0;
    fin_cause = vrmc_pkg::CAUSE_STEP_LIMIT;
    fin_t     = t_ray_q;
    case (st_q)
      ST_IDLE: begin
        if (head_valid_i && !out_valid_q) begin
          deq_o = 1'b1;
          st_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        fin_t = eff_t;
        st_d  = ST_IDLE;
        if (!eff_active) begin
          st_d = ST_IDLE;
        end else if (eff_t <= cfg_i.cutoff) begin
          fin_en    = 1'b1;
          fin_cause = vrmc_pkg::CAUSE_CUTOFF;
        end else if (eff_cnt >= lim) begin
          fin_en    = 1'b1;
          fin_cause = vrmc_pkg::CAUSE_STEP_LIMIT;
        end else if (item_q.item.holdout_hit) begin
          fin_en    = 1'b1;
          fin_cause = vrmc_pkg::CAUSE_HOLDOUT;
        end else begin
          st_d = ST_MULA;
        end
      end
      ST_MULA: begin
        mul_a = {16'd0, item_q.item.extinction};
        mul_b = {16'd0, cfg_i.step_size};
        st_d  = ST_MULX;
      end
      ST_MULX: begin
        mul_a = mul_q[31:0];
        mul_b = {15'd0, item_q.density_sum};
        st_d  = ST_XLOAD;
      end
      ST_XLOAD: begin
        st_d = x_big ? ST_WMUL : ST_RED;
      end
      ST_RED: begin
        if (bit_q == 3'd0) begin
          st_d = ST_EXP0;
        end
      end
      ST_EXP0: begin
        mul_a = {2'd0, r_q[29:0]};
        mul_b = {1'b0, t_q};
        st_d  = ST_EXP1;
      end
      ST_EXP1: begin
        if (m_q == 4'd1) begin
          st_d = ST_DT;
        end else begin
          mul_a = {2'd0, mul_q[59:30]};
          mul_b = {15'd0, rcp[16:0]};
          st_d  = ST_EXP2;
        end
      end
      ST_EXP2: begin
        mul_a = {2'd0, v_q};
        mul_b = {15'd0, rcp[33:17]};
        st_d  = ST_EXP3;
      end
      ST_EXP3: begin
        st_d = ST_EXP0;
      end
      ST_DT: begin
        st_d = ST_WMUL;
      end
      ST_WMUL: begin
        if (item_q.density_sum == 17'd0) begin
          st_d = ST_TMUL;
        end else begin
          mul_a = {8'd0, t_ray_q};
          mul_b = {8'd0, vrmc_pkg::T_ONE - dt_q};
          st_d  = ST_WLOAD;
        end
      end
      ST_WLOAD: begin
        st_d = ST_NUM0;
      end
      ST_NUM0: begin
        mul_a = {16'd0, item_q.item.emit_density};
        mul_b = {16'd0, col_e};
        st_d  = ST_NUM1;
      end
      ST_NUM1: begin
        mul_a = {16'd0, item_q.item.scatter_density};
        mul_b = {16'd0, col_s};
        st_d  = ST_NUM2;
      end
      ST_NUM2: begin
        st_d = ST_DIV;
      end
      ST_DIV: begin
        if (dbit_q == 4'd0) begin
          st_d = ST_ACCM;
        end
      end
      ST_ACCM: begin
        mul_a = {8'd0, w_q};
        mul_b = {16'd0, quo_q};
        st_d  = ST_ACC;
      end
      ST_ACC: begin
        st_d = (ch_q == 2'd2) ? ST_TMUL : ST_NUM0;
      end
      ST_TMUL: begin
        mul_a = {8'd0, t_ray_q};
        mul_b = {8'd0, dt_q};
        st_d  = ST_TFIN;
      end
      ST_TFIN: begin
        fin_t = t_new;
        st_d  = ST_IDLE;
        if (t_new <= cfg_i.cutoff) begin
          fin_en    = 1'b1;
          fin_cause = vrmc_pkg::CAUSE_CUTOFF;
        end else if (cnt_inc >= lim) begin
          fin_en    = 1'b1;
          fin_cause = vrmc_pkg::CAUSE_STEP_LIMIT;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Pixel values of a ray that ends now.
  assign fin_clr   = (st_q == ST_CHECK) && fs;
  assign fin_diff  = vrmc_pkg::T_ONE - fin_t;
  assign fin_alpha = fin_diff[23] ? 16'hFFFF : fin_diff[22:7];

  // Control and ray state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      active_q    <= 1'b0;
      t_ray_q     <= vrmc_pkg::T_ONE;
      sum_q[0]    <= 16'd0;
      sum_q[1]    <= 16'd0;
      sum_q[2]    <= 16'd0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (fin_clr) begin
        t_ray_q  <= vrmc_pkg::T_ONE;
        sum_q[0] <= 16'd0;
        sum_q[1] <= 16'd0;
        sum_q[2] <= 16'd0;
        cnt_q    <= '0;
        active_q <= 1'b1;
      end
      if (st_q == ST_ACC) begin
        sum_q[ch_q] <= acc_sat;
      end
      if (st_q == ST_TFIN) begin
        t_ray_q <= t_new;
        cnt_q   <= cnt_inc;
      end
      if (fin_en) begin
        active_q    <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Arithmetic registers.
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    if (deq_o) begin
      item_q <= head_i;
    end
    if (fin_en) begin
      out_q.pixel_red   <= fin_clr ? 16'd0 : sum_q[0];
      out_q.pixel_green <= fin_clr ? 16'd0 : sum_q[1];
      out_q.pixel_blue  <= fin_clr ? 16'd0 : sum_q[2];
      out_q.pixel_alpha <= fin_alpha;
      out_q.end_cause   <= fin_cause;
    end
    case (st_q)
      ST_XLOAD: begin
        if (x_big) begin
          dt_q <= 24'd0;
        end else begin
          r_q   <= x_val[34:0];
          n_q   <= 5'd0;
          bit_q <= 3'd4;
        end
      end
      ST_RED: begin
        if (r_q >= red_sh) begin
          r_q        <= r_q - red_sh;
          n_q[bit_q] <= 1'b1;
        end
        bit_q <= bit_q - 3'd1;
        if (bit_q == 3'd0) begin
          m_q <= vrmc_pkg::EXP_TERMS;
          t_q <= vrmc_pkg::Q30_ONE;
        end
      end
      ST_EXP1: begin
        if (m_q == 4'd1) begin
          t_q <= vrmc_pkg::Q30_ONE - {1'b0, mul_q[59:30]};
        end else begin
          v_q <= mul_q[59:30];
        end
      end
      ST_EXP2: begin
        pl_q <= mul_q[46:0];
      end
      ST_EXP3: begin
        t_q <= vrmc_pkg::Q30_ONE - {1'b0, exp_quo};
        m_q <= m_q - 4'd1;
      end
      ST_DT: begin
        dt_q <= dt_calc;
      end
      ST_WLOAD: begin
        w_q  <= mul_q[46:23];
        ch_q <= 2'd0;
      end
      ST_NUM1: begin
        num_q <= mul_q[31:0];
      end
      ST_NUM2: begin
        rem_q  <= 33'(num_q) + 33'(mul_q[31:0]);
        quo_q  <= 16'd0;
        dbit_q <= 4'd15;
      end
      ST_DIV: begin
        if (rem_q >= div_sh) begin
          rem_q         <= rem_q - div_sh;
          quo_q[dbit_q] <= 1'b1;
        end
        dbit_q <= dbit_q - 4'd1;
      end
      ST_ACC: begin
        ch_q <= ch_q + 2'd1;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/volume_ray_march_compositor_top.sv =====
// In the back sequencer, a sample that composites runs the eleven-term exponential series
// and the three 16-step mean divides on one shared multiplier; one whose decay factor
// underflows to zero skips the series, a zero-density sample skips the mean divides, and
// an ignored sample or one that ends its ray at the check goes no further than the check.
// A result is registered once its sample finishes; the front queue holds two items.
// Reset clears the queue, the result buffer and the ray, and loads the register defaults.
module volume_ray_march_compositor_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  vrmc_pkg::in_t  in_i,
  output logic           empty,
  input  logic           pop,
  output vrmc_pkg::out_t out_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [23:0]    cfg_data_i
);

  vrmc_pkg::cfg_t  cfg_q;
  logic            head_valid;
  vrmc_pkg::work_t head;
  logic            deq;
  logic            out_valid;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size <= 16'd6554;
      cfg_q.max_steps <= 12'd150;
      cfg_q.cutoff    <= 24'd8;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vrmc_pkg::CFG_STEP_SIZE: cfg_q.step_size <= cfg_data_i[15:0];
        vrmc_pkg::CFG_MAX_STEPS: cfg_q.max_steps <= cfg_data_i[11:0];
        vrmc_pkg::CFG_CUTOFF:    cfg_q.cutoff    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Input queue and classification.
  vrmc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_i         (in_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .deq_i        (deq)
  );

  // Compositing sequencer with its result buffer.
  vrmc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .deq_o        (deq),
    .out_valid_o  (out_valid),
    .out_o        (out_o),
    .pop_i        (pop)
  );

  assign empty = !out_valid;

endmodule
